/* hdl/prqt_pkg.sv */
// ----------------------------------------------------------------------------
// prqt_pkg
// Shared types and constants for the per-id refresh quota table.
// ----------------------------------------------------------------------------
package prqt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 64;
    localparam int CNT_W        = 10;
    localparam int ENT_W        = 6;
    localparam int KIND_W       = 4;
    localparam int RES_MAX      = 32;
    localparam int LIST_W       = $clog2(RES_MAX + 1);

    localparam logic [CNT_W-1:0] COUNT_TOP   = '1;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(50);

    typedef enum logic [KIND_W-1:0] {
        K_ADD      = 4'd0,
        K_DEL      = 4'd1,
        K_CLR      = 4'd2,
        K_CHECK    = 4'd3,
        K_READ     = 4'd4,
        K_INC      = 4'd5,
        K_MARK     = 4'd6,
        K_LIST     = 4'd7,
        K_LIST_CLR = 4'd8,
        K_SIZE     = 4'd9
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] form_id;
    } t_req;

    typedef struct packed {
        logic                    accepted;
        logic                    found;
        logic [CNT_W-1:0]        refresh_count;
        logic signed [KEY_W-1:0] listed_id;
        logic                    listed_valid;
        logic                    last;
        logic [ENT_W-1:0]        entry_total;
    } t_rsp;

    // count and remind mark of one slot
    typedef struct packed {
        logic             remind;
        logic [CNT_W-1:0] count;
    } t_cnt_ent;

    // slot index width
    function automatic int idx_w(input int cap);
        return (cap > 1) ? $clog2(cap) : 1;
    endfunction

endpackage

/* hdl/prqt_stream_if.sv */
// ----------------------------------------------------------------------------
// prqt_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface prqt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/prqt_mem.sv */
// ----------------------------------------------------------------------------
// prqt_mem
// Slot storage: key memory and count/remind memory, shared read address,
// registered read, independent write ports.
// ----------------------------------------------------------------------------
module prqt_mem #(
    parameter int CAPACITY = prqt_pkg::CAPACITY_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rd_en,
    input  logic [prqt_pkg::idx_w(CAPACITY)-1:0]       i_rd_addr,
    output logic signed [prqt_pkg::KEY_W-1:0]          o_rd_key,
    output prqt_pkg::t_cnt_ent                         o_rd_ent,
    input  logic                                       i_key_we,
    input  logic [prqt_pkg::idx_w(CAPACITY)-1:0]       i_key_waddr,
    input  logic signed [prqt_pkg::KEY_W-1:0]          i_key_wdata,
    input  logic                                       i_ent_we,
    input  logic [prqt_pkg::idx_w(CAPACITY)-1:0]       i_ent_waddr,
    input  prqt_pkg::t_cnt_ent                         i_ent_wdata
);
    import prqt_pkg::*;

    logic signed [KEY_W-1:0] r_key_mem [CAPACITY];
    t_cnt_ent                r_ent_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_key_waddr] <= i_key_wdata;
        end
        if (i_rd_en) begin
            o_rd_key <= r_key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_ent_waddr] <= i_ent_wdata;
        end
        if (i_rd_en) begin
            o_rd_ent <= r_ent_mem[i_rd_addr];
        end
    end

endmodule

/* hdl/per_id_refresh_quota_table.sv */
// ----------------------------------------------------------------------------
// per_id_refresh_quota_table
// Table of up to CAPACITY ids, each with a saturating refresh count and a
// remind mark; serves add/delete/clear/check/count/mark/list/size requests.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                        | transfer
//  ---------+-----+------------------------------------------------+-------------
//  i_req    | in  | kind, form_id                                  | valid & ready
//  o_rsp    | out | accepted, found, refresh_count, listed_id,     | valid & ready
//           |     | listed_valid, last, entry_total                |
//  i_cfg_*  | in  | refresh limit                                  | i_cfg_we
//
//  Every request except size (and unused kinds) scans all slots through the
//  slot memories, one slot per cycle while the scan is not stalled. Size and
//  unused kinds skip the scan and go straight to the result. The scan rate
//  is set by the single read port of the slot memories.
//  A list stalls while a new marked id finds the output register still full.
//  Reset (synchronous): all slots empty at once, refresh limit back to 50; no
//  clearing pass. A request is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module per_id_refresh_quota_table #(
    parameter int CAPACITY = prqt_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [prqt_pkg::CNT_W-1:0]    i_cfg_wdata,
    prqt_stream_if.sink                   i_req,
    prqt_stream_if.source                 o_rsp
);
    import prqt_pkg::*;

    localparam int IW = idx_w(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [KIND_W-1:0]       r_kind;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_limit;
    logic [CAPACITY-1:0]     r_used;
    logic [CW-1:0]           r_total;

    // scan pipeline: read issue counter and check stage
    logic [CW-1:0]           r_rd_idx;
    logic                    r_chk_vld;
    logic [IW-1:0]           r_chk_idx;

    // search results
    logic                    r_hit;
    logic [IW-1:0]           r_hit_idx;
    t_cnt_ent                r_hit_ent;
    logic                    r_free;
    logic [IW-1:0]           r_free_idx;

    // list: one marked id held back so the final one can carry last
    logic                    r_pend_vld;
    logic signed [KEY_W-1:0] r_pend_key;
    logic [LIST_W-1:0]       r_nlist;

    t_rsp                    r_res;
    logic                    r_rsp_vld;
    t_rsp                    r_rsp;
    logic                    n_rsp_vld;
    t_rsp                    n_rsp;

    logic signed [KEY_W-1:0] rd_key;
    t_cnt_ent                rd_ent;

    logic     out_free;
    logic     is_named;
    logic     is_list;
    logic     is_clear;
    logic     chk_used;
    logic     list_hit;
    logic     stall;
    logic     rd_en;
    logic     scan_done;
    logic     hit_now;
    logic     free_now;
    logic     req_scan;

    // request phase results
    t_rsp          n_res;
    logic          act_ent_we;
    logic [IW-1:0] act_addr;
    t_cnt_ent      act_ent;
    logic          act_add;
    logic          act_del;

    logic          ent_we;
    logic [IW-1:0] ent_waddr;
    t_cnt_ent      ent_wdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    assign out_free = !r_rsp_vld || o_rsp.ready;

    // requests that name an id
    assign is_named = (r_kind == K_ADD) || (r_kind == K_DEL) || (r_kind == K_CHECK) ||
                      (r_kind == K_READ) || (r_kind == K_INC) || (r_kind == K_MARK);
    assign is_list  = (r_kind == K_LIST) || (r_kind == K_LIST_CLR);
    assign is_clear = (r_kind == K_CLR) || (r_kind == K_LIST_CLR);

    // kinds that need a pass over the slots
    assign req_scan = (i_req.data.kind <= K_LIST_CLR);

    assign chk_used = r_used[r_chk_idx];
    assign list_hit = r_chk_vld && is_list && chk_used && rd_ent.remind &&
                      (r_nlist < LIST_W'(RES_MAX));
    // a new marked id pushes the held one out; wait if the output is busy
    assign stall    = list_hit && r_pend_vld && !out_free;

    assign rd_en     = (r_state == S_SCAN) && (r_rd_idx != CW'(CAPACITY)) && !stall;
    assign scan_done = (r_state == S_SCAN) && (r_rd_idx == CW'(CAPACITY)) && !r_chk_vld;

    // first matching slot and first empty slot, in slot order
    assign hit_now  = r_chk_vld && is_named && chk_used && (rd_key == r_key) && !r_hit;
    assign free_now = r_chk_vld && !chk_used && !r_free;

    // apply the request to the slot found by the scan
    always_comb begin
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] nc;
        c          = r_hit_ent.count;
        nc         = (c != COUNT_TOP) ? c + CNT_W'(1) : c;
        n_res      = '0;
        n_res.last = 1'b1;
        act_ent_we = 1'b0;
        act_addr   = r_hit_idx;
        act_ent    = r_hit_ent;
        act_add    = 1'b0;
        act_del    = 1'b0;
        if (is_named) begin
            n_res.found = r_hit;
        end
        case (r_kind)
            K_ADD: begin
                if (r_hit) begin
                    n_res.accepted      = 1'b1;
                    n_res.refresh_count = c;
                end else if (r_free) begin
                    n_res.accepted = 1'b1;
                    act_add        = 1'b1;
                    act_ent_we     = 1'b1;
                    act_addr       = r_free_idx;
                    act_ent        = '0;
                end
            end
            K_DEL: begin
                act_del = r_hit;
            end
            K_CHECK: begin
                n_res.accepted      = r_hit && (c < r_limit);
                n_res.refresh_count = r_hit ? c : '0;
            end
            K_READ, K_MARK: begin
                n_res.refresh_count = r_hit ? c : '0;
                if ((r_kind == K_MARK) && r_hit && (c >= r_limit)) begin
                    act_ent_we     = 1'b1;
                    act_ent.remind = 1'b1;
                end
            end
            K_INC: begin
                n_res.refresh_count = r_hit ? nc : '0;
                if (r_hit && (c != COUNT_TOP)) begin
                    act_ent_we    = 1'b1;
                    act_ent.count = nc;
                end
            end
            K_LIST, K_LIST_CLR: begin
                n_res.listed_id    = r_pend_vld ? r_pend_key : '0;
                n_res.listed_valid = r_pend_vld;
            end
            default: begin
            end
        endcase
    end

    // output register: listed ids pushed during the scan, final result at S_OUT
    always_comb begin
        n_rsp_vld = r_rsp_vld && !o_rsp.ready;
        n_rsp     = r_rsp;
        if ((r_state == S_SCAN) && list_hit && r_pend_vld && !stall) begin
            n_rsp_vld          = 1'b1;
            n_rsp              = '0;
            n_rsp.listed_id    = r_pend_key;
            n_rsp.listed_valid = 1'b1;
            n_rsp.entry_total  = ENT_W'(r_total);
        end
        if ((r_state == S_OUT) && out_free) begin
            n_rsp_vld         = 1'b1;
            n_rsp             = r_res;
            n_rsp.entry_total = ENT_W'(r_total);
        end
    end

    // count/remind write port: clearing sweep during scan, else request update
    always_comb begin
        if (r_state == S_SCAN) begin
            ent_we    = r_chk_vld && is_clear && !stall;
            ent_waddr = r_chk_idx;
            ent_wdata = '0;
        end else begin
            ent_we    = (r_state == S_ACT) && act_ent_we;
            ent_waddr = act_addr;
            ent_wdata = act_ent;
        end
    end

    prqt_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_en     (rd_en),
        .i_rd_addr   (r_rd_idx[IW-1:0]),
        .o_rd_key    (rd_key),
        .o_rd_ent    (rd_ent),
        .i_key_we    ((r_state == S_ACT) && act_add),
        .i_key_waddr (r_free_idx),
        .i_key_wdata (r_key),
        .i_ent_we    (ent_we),
        .i_ent_waddr (ent_waddr),
        .i_ent_wdata (ent_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_limit    <= LIMIT_RESET;
            r_used     <= '0;
            r_total    <= '0;
            r_rd_idx   <= '0;
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nlist    <= '0;
            r_rsp_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_rsp_vld <= n_rsp_vld;
            r_rsp     <= n_rsp;

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind     <= i_req.data.kind;
                        r_key      <= i_req.data.form_id;
                        r_rd_idx   <= '0;
                        r_chk_vld  <= 1'b0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_pend_vld <= 1'b0;
                        r_nlist    <= '0;
                        r_state    <= req_scan ? S_SCAN : S_ACT;
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        if (rd_en) begin
                            r_rd_idx  <= r_rd_idx + CW'(1);
                            r_chk_idx <= r_rd_idx[IW-1:0];
                            r_chk_vld <= 1'b1;
                        end else begin
                            r_chk_vld <= 1'b0;
                        end
                        if (hit_now) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                            r_hit_ent <= rd_ent;
                        end
                        if (free_now) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                        if (list_hit) begin
                            r_pend_vld <= 1'b1;
                            r_pend_key <= rd_key;
                            r_nlist    <= r_nlist + LIST_W'(1);
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    r_res <= n_res;
                    if (act_add) begin
                        r_used[r_free_idx] <= 1'b1;
                        r_total            <= r_total + CW'(1);
                    end
                    if (act_del) begin
                        r_used[r_hit_idx] <= 1'b0;
                        r_total           <= r_total - CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* test/tb_per_id_refresh_quota_table.sv */
// ----------------------------------------------------------------------------
// tb_per_id_refresh_quota_table
// Self-checking bench for the refresh quota table. A directed opening covers
// empty lists, extreme ids, unknown ids, a full table, a full 32-entry list
// and a steady run of increments at the top limit. Random request mixes then
// run under several limit settings. A shadow of the table predicts
// every response, and each response is compared field by field in arrival
// order.
// ----------------------------------------------------------------------------
module tb_per_id_refresh_quota_table;
    import prqt_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int ID_POOL       = 40;
    localparam int HOT_IDS       = 6;
    localparam int IDLE_PCT      = 35;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 45;
    localparam int TOP_INCS      = 60;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int CYCLE_LIMIT   = 2_000_000;

    // request kinds the block does not define
    localparam logic [KIND_W-1:0] KIND_SPARE = 4'd10;
    localparam logic [KIND_W-1:0] KIND_TOP   = 4'd15;

    localparam logic [KEY_W-1:0] ID_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] ID_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] ID_ZERO = '0;
    localparam logic [KEY_W-1:0] ID_ONES = '1;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    prqt_stream_if #(.T(t_req)) req_if ();
    prqt_stream_if #(.T(t_rsp)) rsp_if ();

    per_id_refresh_quota_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Shadow copy of the table: occupancy, id, count and remind mark per slot.
    logic                    ent_live [CAPACITY];
    logic signed [KEY_W-1:0] ent_id   [CAPACITY];
    logic [CNT_W-1:0]        ent_hits [CAPACITY];
    logic                    ent_flag [CAPACITY];
    logic [CNT_W-1:0]        quota_limit;

    t_req        req_backlog[$];     // requests waiting for the driver
    t_rsp        table_replies[$];   // responses the table still owes
    logic [KEY_W-1:0] id_pool [ID_POOL];

    logic req_moved;                 // request transfer at the last rising edge
    bit   idle_on;                   // random idling on both channels
    bit   hold_pending;              // asks the receiver for one long hold-off
    int   hold_left;
    int   fail_count;
    int   cycle_count;

    // 10 time units per clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------
    function automatic int locate(input logic signed [KEY_W-1:0] id);
        for (int i = 0; i < CAPACITY; i++) begin
            if (ent_live[i] && ent_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [ENT_W-1:0] occupied();
        logic [ENT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (ent_live[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // reset all and list-and-reset both wipe counts and marks of live slots
    task automatic zero_counts();
        for (int i = 0; i < CAPACITY; i++) begin
            if (ent_live[i]) begin
                ent_hits[i] = '0;
                ent_flag[i] = 1'b0;
            end
        end
    endtask

    task automatic table_wipe();
        for (int i = 0; i < CAPACITY; i++) begin
            ent_live[i] = 1'b0;
            ent_id[i]   = '0;
            ent_hits[i] = '0;
            ent_flag[i] = 1'b0;
        end
        quota_limit = LIMIT_RESET;
    endtask

    // Apply one accepted request to the shadow and queue the responses it owes.
    task automatic table_apply(input t_req req);
        int   slot;
        int   marked;
        int   sent;
        logic acc;
        t_rsp r;
        slot   = -1;
        marked = 0;
        sent   = 0;
        acc    = 1'b0;
        r      = '0;
        if (req.kind == K_LIST || req.kind == K_LIST_CLR) begin
            // list in slot order, capped at RES_MAX; last flag on the final one
            for (int i = 0; i < CAPACITY; i++) begin
                if (ent_live[i] && ent_flag[i] && marked < RES_MAX) begin
                    marked++;
                end
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (ent_live[i] && ent_flag[i] && sent < marked) begin
                    r              = '0;
                    r.listed_id    = ent_id[i];
                    r.listed_valid = 1'b1;
                    r.last         = (sent + 1 == marked);
                    r.entry_total  = occupied();
                    table_replies.push_back(r);
                    sent++;
                end
            end
            if (marked == 0) begin
                r             = '0;
                r.last        = 1'b1;
                r.entry_total = occupied();
                table_replies.push_back(r);
            end
            if (req.kind == K_LIST_CLR) begin
                zero_counts();
            end
        end else begin
            if (req.kind <= K_MARK && req.kind != K_CLR) begin
                slot = locate(req.form_id);
            end
            case (req.kind)
                K_ADD: begin
                    if (slot >= 0) begin
                        acc = 1'b1;
                    end else begin
                        // lowest empty slot wins; a full table refuses
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (!ent_live[i] && !acc) begin
                                ent_live[i] = 1'b1;
                                ent_id[i]   = req.form_id;
                                ent_hits[i] = '0;
                                ent_flag[i] = 1'b0;
                                acc         = 1'b1;
                            end
                        end
                    end
                end
                K_DEL: begin
                    if (slot >= 0) begin
                        ent_live[slot] = 1'b0;
                    end
                end
                K_CLR: begin
                    zero_counts();
                end
                K_CHECK: begin
                    if (slot >= 0 && ent_hits[slot] < quota_limit) begin
                        acc = 1'b1;
                    end
                end
                K_INC: begin
                    if (slot >= 0 && ent_hits[slot] != COUNT_TOP) begin
                        ent_hits[slot]++;
                    end
                end
                K_MARK: begin
                    if (slot >= 0 && ent_hits[slot] >= quota_limit) begin
                        ent_flag[slot] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.accepted = acc;
            r.found    = (slot >= 0);
            if (slot >= 0 && req.kind != K_DEL) begin
                r.refresh_count = ent_hits[slot];
            end
            r.last        = 1'b1;
            r.entry_total = occupied();
            table_replies.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: sample transfers, update the shadow, compare responses.
    // Inputs are driven at the falling edge, so everything read here is stable.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            table_wipe();
            req_moved = 1'b0;
        end else begin
            if (i_cfg_we) begin
                quota_limit = i_cfg_wdata;
            end
            req_moved = req_if.valid && req_if.ready;
            if (req_moved) begin
                table_apply(req_if.data);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (table_replies.size() == 0) begin
                    $display("%0t: response with none outstanding: expected nothing, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = table_replies.pop_front();
                    check_field("accepted", KEY_W'(want.accepted), KEY_W'(got.accepted));
                    check_field("found", KEY_W'(want.found), KEY_W'(got.found));
                    check_field("refresh_count", KEY_W'(want.refresh_count),
                                KEY_W'(got.refresh_count));
                    check_field("listed_id", want.listed_id, got.listed_id);
                    check_field("listed_valid", KEY_W'(want.listed_valid),
                                KEY_W'(got.listed_valid));
                    check_field("last", KEY_W'(want.last), KEY_W'(got.last));
                    check_field("entry_total", KEY_W'(want.entry_total),
                                KEY_W'(got.entry_total));
                end
            end
        end
    end

    // Request driver: a held item stays on the bus until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_moved) begin
            if (req_backlog.size() != 0 &&
                !(idle_on && $urandom_range(0, 99) < IDLE_PCT)) begin
                req_if.valid <= 1'b1;
                req_if.data  <= req_backlog.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response receiver: random back-pressure plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_req(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] id);
        t_req q;
        q.kind    = kind;
        q.form_id = id;
        req_backlog.push_back(q);
    endtask

    // Sender stops until every outstanding response has come back.
    task automatic drain();
        while (req_backlog.size() != 0 || req_if.valid || table_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed traffic on a few hot ids so counts reach the limit,
    // with the rest spread over the pool, fresh ids and arbitrary kinds.
    task automatic push_random();
        int               pick;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  id;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            id = id_pool[$urandom_range(0, HOT_IDS - 1)];
        end else if (pick < 92) begin
            id = id_pool[$urandom_range(0, ID_POOL - 1)];
        end else begin
            id = {$urandom, $urandom};
        end
        pick = $urandom_range(0, 99);
        if      (pick < 14) kind = K_ADD;
        else if (pick < 20) kind = K_DEL;
        else if (pick < 22) kind = K_CLR;
        else if (pick < 32) kind = K_CHECK;
        else if (pick < 39) kind = K_READ;
        else if (pick < 67) kind = K_INC;
        else if (pick < 80) kind = K_MARK;
        else if (pick < 86) kind = K_LIST;
        else if (pick < 89) kind = K_LIST_CLR;
        else if (pick < 94) kind = K_SIZE;
        else if (pick < 96) kind = KIND_SPARE + KIND_W'($urandom_range(0, KIND_TOP - KIND_SPARE));
        else                kind = KIND_W'($urandom_range(0, KIND_TOP));
        push_req(kind, id);
    endtask

    initial begin
        logic [CNT_W-1:0] phase_limit [4];
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        req_moved    = 1'b0;
        idle_on      = 1'b1;
        hold_pending = 1'b0;
        hold_left    = 0;
        fail_count   = 0;
        cycle_count  = 0;

        id_pool[0] = ID_MIN;
        id_pool[1] = ID_MAX;
        id_pool[2] = ID_ZERO;
        id_pool[3] = ID_ONES;
        for (int i = 4; i < ID_POOL; i++) begin
            id_pool[i] = {$urandom, $urandom};
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset limit: empty table, extreme ids,
        // duplicate add, unknown ids, reset all, undefined kinds.
        push_req(K_SIZE, ID_ZERO);
        push_req(K_LIST, ID_ZERO);
        push_req(K_LIST_CLR, ID_ZERO);
        push_req(K_ADD, ID_MIN);
        push_req(K_ADD, ID_MAX);
        push_req(K_ADD, ID_ZERO);
        push_req(K_ADD, ID_ONES);
        push_req(K_ADD, ID_MAX);
        push_req(K_CHECK, ID_MIN);
        push_req(K_INC, ID_MIN);
        push_req(K_READ, ID_MIN);
        push_req(K_MARK, ID_MIN);          // below limit: no mark
        push_req(K_LIST, ID_ZERO);
        push_req(K_DEL, ID_ZERO);
        push_req(K_DEL, ID_ZERO);          // already gone
        push_req(K_INC, ID_ZERO);
        push_req(K_MARK, ID_ZERO);
        push_req(K_CHECK, ID_ZERO);
        push_req(K_READ, ID_ZERO);
        push_req(K_ADD, ID_ZERO);          // refills the freed slot
        push_req(K_CLR, ID_ONES);
        push_req(K_READ, ID_MIN);
        push_req(KIND_SPARE, ID_MAX);
        push_req(KIND_TOP, ID_ONES);
        push_req(K_SIZE, ID_MAX);
        drain();

        // Limit 1: fill the table, overflow it, mark every slot and list all
        // 32. The receiver holds off at the start so the block backs up.
        write_limit(CNT_W'(1));
        hold_pending = 1'b1;
        for (int i = HOT_IDS - 2; i < CAPACITY; i++) begin
            push_req(K_ADD, id_pool[i]);
        end
        push_req(K_ADD, id_pool[CAPACITY]);   // table full: refused
        for (int i = 0; i < CAPACITY; i++) begin
            push_req(K_INC, id_pool[i]);
        end
        push_req(K_CHECK, id_pool[5]);
        for (int i = 0; i < CAPACITY; i++) begin
            push_req(K_MARK, id_pool[i]);
        end
        push_req(K_LIST, ID_ZERO);
        push_req(K_LIST_CLR, ID_ZERO);
        push_req(K_LIST, ID_ZERO);
        push_req(K_READ, id_pool[7]);
        drain();

        // Top limit, no idling on either side: a steady run of increments
        // on one id, always below the limit.
        write_limit(COUNT_TOP);
        idle_on = 1'b0;
        for (int i = 0; i < TOP_INCS; i++) begin
            push_req(K_INC, ID_MIN);
        end
        push_req(K_CHECK, ID_MIN);
        push_req(K_READ, ID_MIN);
        push_req(K_MARK, ID_MIN);
        push_req(K_LIST, ID_ZERO);
        push_req(K_LIST_CLR, ID_ZERO);
        push_req(K_READ, ID_MIN);
        drain();
        idle_on = 1'b1;

        // Random traffic under low limits so marks and lists come often;
        // the last phase goes back to the reset value.
        phase_limit[0] = CNT_W'(2);
        phase_limit[1] = CNT_W'(1);
        phase_limit[2] = CNT_W'($urandom_range(1, 4));
        phase_limit[3] = LIMIT_RESET;
        for (int p = 0; p < 4; p++) begin
            write_limit(phase_limit[p]);
            for (int i = 0; i < RANDOM_ITEMS; i++) begin
                push_random();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && table_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
